FILE: src/dqdot_pkg.sv
// Shared types, codes and floating-point helper functions for the dequantising dot unit.
package dqdot_pkg;

   localparam logic [1:0] FMT_BF16 = 2'd1;
   localparam logic [1:0] FMT_HALF = 2'd2;
   localparam logic       REG_SYM  = 1'b0;
   localparam logic       REG_FMT  = 1'b1;
   localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;

   typedef struct packed {
      logic [31:0]        act_quad;
      logic [15:0]        weight_quad;
      logic signed [7:0]  weight_zero;
      logic [7:0]         act_zero;
      logic [31:0]        act_scale;
      logic [31:0]        weight_scale;
      logic [31:0]        bias_value;
      logic               first_item;
      logic               chunk_end;
      logic               last_item;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_COMP, ST_CVT, ST_MUL1, ST_MUL2, ST_ADD, ST_EMIT
   } state_type;

   function automatic logic [31:0] f_round(input logic s, input logic signed [11:0] ex_i,
                                           input logic [50:0] mt_i);
      logic [50:0]        mt;
      logic signed [11:0] ex;
      logic [5:0]         lz;
      logic               found;
      logic [11:0]        sh;
      logic [50:0]        mask;
      logic               lost;
      logic [24:0]        m;
      logic               g;
      logic               st;
      logic [7:0]         fe;
      mt = mt_i;
      ex = ex_i;
      lz = '0;
      found = 1'b0;
      for (int i = 50; i >= 0; i--) begin
         if (!found) begin
            if (mt[i]) found = 1'b1;
            else lz = lz + 6'd1;
         end
      end
      mt = mt << lz;
      ex = ex - $signed({6'b0, lz});
      if (ex < 12'sd1) begin
         sh = 12'(12'sd1 - ex);
         if (sh >= 12'd51) begin
            lost = |mt;
            mt = '0;
         end else begin
            mask = (51'(1) << sh[5:0]) - 51'(1);
            lost = |(mt & mask);
            mt = mt >> sh[5:0];
         end
         mt[0] = mt[0] | lost;
         ex = 12'sd1;
      end
      m = {1'b0, mt[50:27]};
      g = mt[26];
      st = |mt[25:0];
      if (g && (st || m[0])) m = m + 25'd1;
      if (m[24]) begin
         m = m >> 1;
         ex = ex + 12'sd1;
      end
      if (ex >= 12'sd255) return {s, 8'hff, 23'b0};
      fe = m[23] ? ex[7:0] : 8'd0;
      return {s, fe, m[22:0]};
   endfunction

   function automatic logic [31:0] int_to_float(input logic [31:0] acc);
      logic [31:0] mag;
      mag = acc[31] ? (32'd0 - acc) : acc;
      if (acc == 32'd0) return 32'd0;
      return f_round(acc[31], 12'sd158, {mag, 19'b0});
   endfunction

   function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
      logic               an, bn, ai, bi, az, bz, s;
      logic [23:0]        sa, sb;
      logic [47:0]        p;
      logic signed [11:0] ex;
      an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      ai = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      bi = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      az = (a[30:0] == 31'd0);
      bz = (b[30:0] == 31'd0);
      s = a[31] ^ b[31];
      sa = {a[30:23] != 8'd0, a[22:0]};
      sb = {b[30:23] != 8'd0, b[22:0]};
      p = sa * sb;
      ex = $signed({4'b0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
         + $signed({4'b0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 12'sd126;
      if (an) return a | 32'h0040_0000;
      if (bn) return b | 32'h0040_0000;
      if ((ai && bz) || (bi && az)) return DEFAULT_NAN;
      if (ai || bi) return {s, 8'hff, 23'b0};
      if (az || bz) return {s, 31'b0};
      return f_round(s, ex, {p, 3'b0});
   endfunction

   function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
      logic        an, bn, ai, bi;
      logic [31:0] x, y;
      logic [7:0]  ex, ey, d;
      logic [49:0] xw, yw, ys, mask;
      logic        lost;
      logic [50:0] sum;
      an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      ai = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      bi = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d = ex - ey;
      xw = {x[30:23] != 8'd0, x[22:0], 26'b0};
      yw = {y[30:23] != 8'd0, y[22:0], 26'b0};
      if (d >= 8'd50) begin
         ys = '0;
         lost = |yw;
      end else begin
         mask = (50'(1) << d[5:0]) - 50'(1);
         lost = |(yw & mask);
         ys = yw >> d[5:0];
      end
      ys[0] = ys[0] | lost;
      sum = (x[31] == y[31]) ? ({1'b0, xw} + {1'b0, ys}) : ({1'b0, xw} - {1'b0, ys});
      if (an) return a | 32'h0040_0000;
      if (bn) return b | 32'h0040_0000;
      if (ai && bi && (a[31] != b[31])) return DEFAULT_NAN;
      if (ai) return a;
      if (bi) return b;
      if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'b0};
      if (sum == 51'd0) return 32'd0;
      return f_round(x[31], $signed({4'b0, ex}) + 12'sd1, sum);
   endfunction

   function automatic logic [31:0] to_bf16(input logic [31:0] f);
      logic [31:0] t;
      t = f + 32'h0000_7fff + {31'b0, f[16]};
      if ((f[30:23] == 8'hff) && (f[22:0] != 23'd0)) return 32'h0000_7fc0;
      return {16'b0, t[31:16]};
   endfunction

   function automatic logic [31:0] to_half(input logic [31:0] f);
      logic [15:0]       sg;
      logic signed [9:0] e;
      logic [15:0]       val;
      logic [12:0]       rem13;
      logic [23:0]       m;
      logic [4:0]        sh;
      logic [23:0]       rem, halfway, mask;
      logic [23:0]       v24;
      sg = {f[31], 15'b0};
      e = $signed({2'b0, f[30:23]}) - 10'sd127;
      val = {1'b0, 5'(e + 10'sd15), f[22:13]};
      rem13 = f[12:0];
      m = {1'b1, f[22:0]};
      sh = 5'(-e - 10'sd1);
      mask = (24'(1) << sh) - 24'(1);
      v24 = m >> sh;
      rem = m & mask;
      halfway = 24'(1) << (sh - 5'd1);
      if (f[30:23] == 8'hff) return {16'b0, sg | ((f[22:0] != 23'd0) ? 16'h7e00 : 16'h7c00)};
      if ((f[30:23] == 8'd0) || (e < -10'sd25)) return {16'b0, sg};
      if (e > 10'sd15) return {16'b0, sg | 16'h7c00};
      if (e >= -10'sd14) begin
         if ((rem13 > 13'h1000) || ((rem13 == 13'h1000) && val[0])) val = val + 16'd1;
         return {16'b0, sg | val};
      end
      if ((rem > halfway) || ((rem == halfway) && v24[0])) v24 = v24 + 24'd1;
      return {16'b0, sg | v24[15:0]};
   endfunction

   function automatic logic [31:0] format_out(input logic [31:0] f, input logic [1:0] fmt);
      logic [31:0] r;
      unique case (fmt)
         FMT_BF16: r = to_bf16(f);
         FMT_HALF: r = to_half(f);
         default:  r = f;
      endcase
      return r;
   endfunction

endpackage

FILE: src/dqdot_front.sv
// Input queue that takes words, folds last into chunk end and holds them for the back end.
module dqdot_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  dqdot_pkg::item_type in_item,
   output logic                head_valid,
   output dqdot_pkg::item_type head_item,
   input  logic                head_pop
);
   import dqdot_pkg::*;

   item_type   q_ff [2];
   item_type   q_in [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      do_push = push && !full;
      do_pop = head_pop && head_valid;
      q_in = q_ff;
      if (do_push) begin
         q_in[wr_ff] = in_item;
         q_in[wr_ff].chunk_end = in_item.chunk_end | in_item.last_item;
      end
      wr_in = do_push ? !wr_ff : wr_ff;
      rd_in = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   assign full = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_item = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: src/dqdot_back.sv
// Sequencer that accumulates the integer sums and performs dequantisation and output formatting.
module dqdot_back #(
   parameter int LANES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sym,
   input  logic [1:0]          fmt,
   input  logic                head_valid,
   input  dqdot_pkg::item_type head_item,
   output logic                head_pop,
   output logic                rsp_empty,
   output logic [31:0]         rsp_result_bits,
   input  logic                rsp_pop
);
   import dqdot_pkg::*;

   localparam int AW  = (LANES * 8 > 32) ? LANES * 8 : 32;
   localparam int WW  = (LANES * 4 > 16) ? LANES * 4 : 16;
   localparam int LSW = 17 + $clog2(LANES + 1);
   localparam int WSW = 9 + $clog2(LANES + 1);

   state_type        state_ff, state_in;
   logic [31:0]      dot_ff, dot_in, wsum_ff, wsum_in, fsum_ff, fsum_in;
   logic [31:0]      acc_ff, acc_in, val_ff, val_in;
   logic [7:0]       az_ff, az_in;
   logic [31:0]      ascale_ff, ascale_in, wscale_ff, wscale_in;
   logic             last_ff, last_in;
   logic             valid_ff, valid_in;
   logic [31:0]      bits_ff, bits_in;
   logic [AW-1:0]    act_ext;
   logic [WW-1:0]    wt_ext;
   logic signed [LSW-1:0] lsum;
   logic signed [WSW-1:0] wlsum;
   logic signed [7:0]     wq;
   logic [8:0]            a9;
   logic [31:0]           base_dot, base_w;
   logic signed [32:0]    t;

   always_comb begin
      act_ext = AW'(head_item.act_quad);
      wt_ext = WW'(head_item.weight_quad);
      lsum = '0;
      wlsum = '0;
      for (int j = 0; j < LANES; j++) begin
         wq = 8'({4'b0, wt_ext[4*j +: 4]}) - head_item.weight_zero;
         a9 = sym ? {act_ext[8*j+7], act_ext[8*j +: 8]} : {1'b0, act_ext[8*j +: 8]};
         lsum = lsum + LSW'($signed(a9) * wq);
         wlsum = wlsum + WSW'(wq);
      end
      base_dot = head_item.first_item ? 32'd0 : dot_ff;
      base_w = head_item.first_item ? 32'd0 : wsum_ff;
      t = $signed({base_dot[31], base_dot}) + 33'(lsum);
   end

   always_comb begin
      state_in = state_ff;
      dot_in = dot_ff;
      wsum_in = wsum_ff;
      fsum_in = fsum_ff;
      acc_in = acc_ff;
      val_in = val_ff;
      az_in = az_ff;
      ascale_in = ascale_ff;
      wscale_in = wscale_ff;
      last_in = last_ff;
      valid_in = valid_ff && !rsp_pop;
      bits_in = bits_ff;
      head_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (head_item.first_item) fsum_in = head_item.bias_value;
               wsum_in = base_w + 32'(wlsum);
               if (!sym) dot_in = base_dot + 32'(lsum);
               else if (t[32] != t[31]) dot_in = t[32] ? 32'h8000_0000 : 32'h7fff_ffff;
               else dot_in = t[31:0];
               az_in = head_item.act_zero;
               ascale_in = head_item.act_scale;
               wscale_in = head_item.weight_scale;
               last_in = head_item.last_item;
               if (head_item.chunk_end) state_in = ST_COMP;
            end
         end
         ST_COMP: begin
            acc_in = sym ? dot_ff : dot_ff - 32'(az_ff * wsum_ff);
            dot_in = '0;
            wsum_in = '0;
            state_in = ST_CVT;
         end
         ST_CVT: begin
            val_in = int_to_float(acc_ff);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            val_in = f_mul(val_ff, ascale_ff);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            val_in = f_mul(val_ff, wscale_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            fsum_in = f_add(val_ff, fsum_ff);
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!valid_ff || rsp_pop) begin
               valid_in = 1'b1;
               bits_in = format_out(fsum_ff, fmt);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_empty = !valid_ff;
   assign rsp_result_bits = bits_ff;

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      val_ff <= val_in;
      az_ff <= az_in;
      ascale_ff <= ascale_in;
      wscale_ff <= wscale_in;
      last_ff <= last_in;
      bits_ff <= bits_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         dot_ff <= '0;
         wsum_ff <= '0;
         fsum_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dot_ff <= dot_in;
         wsum_ff <= wsum_in;
         fsum_ff <= fsum_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> state_ff == ST_IDLE) else $error("word taken outside idle");
   a_comp_cvt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMP |=> state_ff == ST_CVT) else $error("chunk sequence broken");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !valid_ff |=> valid_ff) else $error("result not written");
`endif
endmodule

FILE: src/int4_int8_dequant_dot_accumulate_unit.sv
// Top level of the int4-weight, 8-bit-activation dequantising dot-product accumulator.
// A word waits in the two-word queue until the idle back-end sequencer absorbs it.
// A chunk-end word takes the sequencer through compensate, convert, scale multiplies and add;
// a last word then waits in emit until the result register is free and writes its result.
// Throughput: one word per cycle between chunk ends, set by the single integer accumulate step.
// Reset clears the queue, the sums, the float accumulator to +0.0 and both registers.
module int4_int8_dequant_dot_accumulate_unit #(
   parameter int LANES = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [31:0]        req_act_quad,
   input  logic [15:0]        req_weight_quad,
   input  logic signed [7:0]  req_weight_zero,
   input  logic [7:0]         req_act_zero,
   input  logic [31:0]        req_act_scale,
   input  logic [31:0]        req_weight_scale,
   input  logic [31:0]        req_bias_value,
   input  logic               req_first_item,
   input  logic               req_chunk_end,
   input  logic               req_last_item,
   output logic               empty,
   input  logic               pop,
   output logic [31:0]        rsp_result_bits,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import dqdot_pkg::*;

   logic       sym_ff, sym_in;
   logic [1:0] fmt_ff, fmt_in;
   item_type   in_item, head_item;
   logic       head_valid, head_pop;

   always_comb begin
      sym_in = sym_ff;
      fmt_in = fmt_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_SYM: sym_in = pwdata[0];
            REG_FMT: fmt_in = pwdata[1:0];
            default: sym_in = sym_ff;
         endcase
      end
      unique case (paddr[2])
         REG_SYM: prdata = {31'b0, sym_ff};
         REG_FMT: prdata = {30'b0, fmt_ff};
         default: prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= 1'b0;
         fmt_ff <= 2'd0;
      end else begin
         sym_ff <= sym_in;
         fmt_ff <= fmt_in;
      end
   end

   assign in_item = '{act_quad: req_act_quad, weight_quad: req_weight_quad,
                      weight_zero: req_weight_zero, act_zero: req_act_zero,
                      act_scale: req_act_scale, weight_scale: req_weight_scale,
                      bias_value: req_bias_value, first_item: req_first_item,
                      chunk_end: req_chunk_end, last_item: req_last_item};

   dqdot_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .in_item    (in_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   dqdot_back #(.LANES(LANES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .sym             (sym_ff),
      .fmt             (fmt_ff),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop),
      .rsp_empty       (empty),
      .rsp_result_bits (rsp_result_bits),
      .rsp_pop         (pop)
   );
endmodule
